/* hdl/qrt_pkg.sv */
`default_nettype none

package qrt_pkg;

	localparam int COORD_W   = 20;
	localparam int QUAT_W    = 16;
	localparam int OFF_W     = 3 * COORD_W;
	localparam int CFG_IDX_W = 3;

	// cfg_data carries the widest register
	localparam int CFG_DATA_W = (OFF_W > QUAT_W) ? OFF_W : QUAT_W;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [QUAT_W-1:0]  quat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_W,
		REG_ROT_X,
		REG_ROT_Y,
		REG_ROT_Z,
		REG_PRE_OFF,
		REG_POST_OFF
	} reg_idx_t;

	localparam logic CMD_APPLY  = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef struct packed {
		logic   cmd;
		coord_t in_x;
		coord_t in_y;
		coord_t in_z;
	} point_t;

	typedef struct packed {
		coord_t out_x;
		coord_t out_y;
		coord_t out_z;
		logic   clipped;
	} result_t;

	// register file contents seen by the datapath, offsets x at index 0
	typedef struct packed {
		quat_t        rot_w;
		quat_t        rot_x;
		quat_t        rot_y;
		quat_t        rot_z;
		coord_t [2:0] pre_off;
		coord_t [2:0] post_off;
	} cfg_t;

endpackage

`default_nettype wire

/* hdl/quaternion_rigid_transform_top.sv */
// an accepted point passes through the stage 1 to stage 6 registers and appears on result from the stage 6 register
// throughput: one point per cycle while result_stall is low, set by the six-stage pipeline
// a result stall backs up stage by stage; bubbles close up, nothing is dropped
// reset clears all stage valid bits, loads the identity rotation and zero offsets
// configuration writes are registered, read directly by the pipeline and always ready
`default_nettype none

module quaternion_rigid_transform_top import qrt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  point_valid,
	output logic                       point_stall,
	input  wire point_t                point,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result
);

	cfg_t cfg;

	qrt_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qrt_pipe u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

/* hdl/qrt_regs.sv */
`default_nettype none

module qrt_regs import qrt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_w    <= {1'b0, {(QUAT_W-1){1'b1}}};
			cfg_q.rot_x    <= '0;
			cfg_q.rot_y    <= '0;
			cfg_q.rot_z    <= '0;
			cfg_q.pre_off  <= '0;
			cfg_q.post_off <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ROT_W: cfg_q.rot_w <= cfg_data[QUAT_W-1:0];
				REG_ROT_X: cfg_q.rot_x <= cfg_data[QUAT_W-1:0];
				REG_ROT_Y: cfg_q.rot_y <= cfg_data[QUAT_W-1:0];
				REG_ROT_Z: cfg_q.rot_z <= cfg_data[QUAT_W-1:0];
				REG_PRE_OFF: begin
					for (int i = 0; i < 3; i++) begin
						cfg_q.pre_off[i] <= cfg_data[i*COORD_W +: COORD_W];
					end
				end
				REG_POST_OFF: begin
					for (int i = 0; i < 3; i++) begin
						cfg_q.post_off[i] <= cfg_data[i*COORD_W +: COORD_W];
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/qrt_pipe.sv */
`default_nettype none

module qrt_pipe import qrt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   point_valid,
	output logic        point_stall,
	input  wire point_t point,
	output logic        result_valid,
	input  wire logic   result_stall,
	output result_t     result
);

	localparam int V_W   = COORD_W + 1;
	localparam int P1_W  = QUAT_W + V_W;
	localparam int T_W   = P1_W + 2;
	localparam int P2_W  = T_W + QUAT_W;
	localparam int S_W   = P2_W + 2;
	localparam int RND   = 2 * (QUAT_W - 1);
	localparam int R_W   = S_W - RND;
	localparam int F_W   = R_W + 1;

	localparam logic signed [S_W-1:0] RND_HALF =
		{{(S_W-RND){1'b0}}, 1'b1, {(RND-1){1'b0}}};
	localparam logic signed [F_W-1:0] SAT_HI = {{(F_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [F_W-1:0] SAT_LO = {{(F_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	quat_t qv [4];

	assign qv[0] = cfg.rot_w;
	assign qv[1] = cfg.rot_x;
	assign qv[2] = cfg.rot_y;
	assign qv[3] = cfg.rot_z;

	// stage enables, a stage moves when it is empty or the next one moves
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	always_comb begin
		en_s6 = !vld_s6 || !result_stall;
		en_s5 = !vld_s5 || en_s6;
		en_s4 = !vld_s4 || en_s5;
		en_s3 = !vld_s3 || en_s4;
		en_s2 = !vld_s2 || en_s3;
		en_s1 = !vld_s1 || en_s2;
	end

	assign point_stall  = !en_s1;
	assign result_valid = vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= point_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: first translation
	coord_t              pin [3];
	logic signed [V_W-1:0] v_nx [3];
	logic signed [V_W-1:0] v_s1 [3];
	logic                  cmd_s1;

	assign pin[0] = point.in_x;
	assign pin[1] = point.in_y;
	assign pin[2] = point.in_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (point.cmd == CMD_REMOVE) begin
				v_nx[i] = V_W'(pin[i]) - V_W'($signed(cfg.post_off[i]));
			end else begin
				v_nx[i] = V_W'(pin[i]) + V_W'($signed(cfg.pre_off[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			v_s1   <= v_nx;
			cmd_s1 <= point.cmd;
		end
	end

	// stage 2: every quaternion component times every coordinate
	logic signed [P1_W-1:0] m1_s2 [4][3];
	logic                   cmd_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int j = 0; j < 4; j++) begin
				for (int i = 0; i < 3; i++) begin
					m1_s2[j][i] <= P1_W'(qv[j]) * P1_W'(v_s1[i]);
				end
			end
			cmd_s2 <= cmd_s1;
		end
	end

	// stage 3: first hamilton product, conjugate folded into the signs
	logic signed [T_W-1:0] dot, e_v [3];
	logic signed [T_W-1:0] t_nx [4];
	logic signed [T_W-1:0] t_s3 [4];
	logic                  cmd_s3;

	always_comb begin
		dot    = T_W'(m1_s2[1][0]) + T_W'(m1_s2[2][1]) + T_W'(m1_s2[3][2]);
		e_v[0] = T_W'(m1_s2[2][2]) - T_W'(m1_s2[3][1]);
		e_v[1] = T_W'(m1_s2[3][0]) - T_W'(m1_s2[1][2]);
		e_v[2] = T_W'(m1_s2[1][1]) - T_W'(m1_s2[2][0]);
		if (cmd_s2 == CMD_REMOVE) begin
			t_nx[0] = dot;
			for (int i = 0; i < 3; i++) t_nx[i+1] = T_W'(m1_s2[0][i]) - e_v[i];
		end else begin
			t_nx[0] = -dot;
			for (int i = 0; i < 3; i++) t_nx[i+1] = T_W'(m1_s2[0][i]) + e_v[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			t_s3   <= t_nx;
			cmd_s3 <= cmd_s2;
		end
	end

	// stage 4: second product terms, r_i = w_i + sign * (a_i + b_i - c_i)
	logic signed [P2_W-1:0] w_s4 [3], a_s4 [3], b_s4 [3], c_s4 [3];
	logic                   cmd_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int i = 0; i < 3; i++) begin
				w_s4[i] <= P2_W'(t_s3[i+1]) * P2_W'(qv[0]);
				a_s4[i] <= P2_W'(t_s3[0]) * P2_W'(qv[i+1]);
			end
			b_s4[0] <= P2_W'(t_s3[2]) * P2_W'(qv[3]);
			c_s4[0] <= P2_W'(t_s3[3]) * P2_W'(qv[2]);
			b_s4[1] <= P2_W'(t_s3[3]) * P2_W'(qv[1]);
			c_s4[1] <= P2_W'(t_s3[1]) * P2_W'(qv[3]);
			b_s4[2] <= P2_W'(t_s3[1]) * P2_W'(qv[2]);
			c_s4[2] <= P2_W'(t_s3[2]) * P2_W'(qv[1]);
			cmd_s4  <= cmd_s3;
		end
	end

	// stage 5: sum and round half up
	logic signed [S_W-1:0] x_sum [3], r_sum [3];
	logic signed [R_W-1:0] r_s5 [3];
	logic                  cmd_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			x_sum[i] = S_W'(a_s4[i]) + S_W'(b_s4[i]) - S_W'(c_s4[i]);
			if (cmd_s4 == CMD_REMOVE) begin
				r_sum[i] = S_W'(w_s4[i]) + x_sum[i] + RND_HALF;
			end else begin
				r_sum[i] = S_W'(w_s4[i]) - x_sum[i] + RND_HALF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int i = 0; i < 3; i++) r_s5[i] <= r_sum[i][S_W-1:RND];
			cmd_s5 <= cmd_s4;
		end
	end

	// stage 6: second translation, saturate into the output register
	logic signed [F_W-1:0] f_sum [3];
	coord_t                f_sat [3];
	logic                  f_clip;
	result_t               result_s6;

	always_comb begin
		f_clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (cmd_s5 == CMD_REMOVE) begin
				f_sum[i] = F_W'(r_s5[i]) - F_W'($signed(cfg.pre_off[i]));
			end else begin
				f_sum[i] = F_W'(r_s5[i]) + F_W'($signed(cfg.post_off[i]));
			end
			if (f_sum[i] > SAT_HI) begin
				f_sat[i] = COORD_MAX;
				f_clip   = 1'b1;
			end else if (f_sum[i] < SAT_LO) begin
				f_sat[i] = COORD_MIN;
				f_clip   = 1'b1;
			end else begin
				f_sat[i] = f_sum[i][COORD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			result_s6.out_x   <= f_sat[0];
			result_s6.out_y   <= f_sat[1];
			result_s6.out_z   <= f_sat[2];
			result_s6.clipped <= f_clip;
		end
	end

	assign result = result_s6;

	// input backs up only when every stage holds a beat and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6
			&& result_stall))
		else $error("input stalled with a bubble in the pipeline");

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.clipped) |->
			(result.out_x == COORD_MAX || result.out_x == COORD_MIN ||
			 result.out_y == COORD_MAX || result.out_y == COORD_MIN ||
			 result.out_z == COORD_MAX || result.out_z == COORD_MIN))
		else $error("clip flag set with no coordinate on a rail");

	a_last_move: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && en_s6) |=> result_valid)
		else $error("beat lost entering the output register");

	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !en_s4) |=> (vld_s3 && $stable(cmd_s3) && $stable(t_s3[0])))
		else $error("held stage 3 beat changed");

endmodule

`default_nettype wire
